### sv/gregorian_date_calculator_macros.svh
// Assertion macros shared by the checker of the date calculator.
`ifndef GREGORIAN_DATE_CALCULATOR_MACROS_SVH
`define GREGORIAN_DATE_CALCULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define GDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdc check failed");

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define GDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdc check failed");

`endif

### sv/gdc_pkg.sv
// Types, constants and calendar helper functions of the date calculator.
`default_nettype none
package gdc_pkg;

  localparam int MAX_YEAR    = 9999;
  localparam int OFFSET_BITS = 21;

  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int DIFF_W = 23;
  localparam int SER_W  = 23;
  localparam int SM_W   = ((OFFSET_BITS > SER_W) ? OFFSET_BITS : SER_W) + 2;

  localparam int DIVD_W = 24;
  localparam int DIVS_W = 18;

  localparam int ERA_DAYS  = 146097;
  localparam int ERA_YEARS = 400;

  // Reciprocals for the constant divides. Each shift is the dividend width plus
  // the bit length of the divisor, which makes the truncated quotient exact.
  localparam int RCP_W   = 23;
  localparam int SH_400  = 24;  // shifted years, below 2^15
  localparam int SH_ERA  = 40;  // day numbers, below 2^22
  localparam int SH_1460 = 29;  // day of era, below 2^18
  localparam int SH_365  = 27;  // day of era numerator, below 2^18
  localparam logic [RCP_W-1:0] RCP_400  =
    RCP_W'(((64'd1 << SH_400) + 64'(ERA_YEARS) - 64'd1) / 64'(ERA_YEARS));
  localparam logic [RCP_W-1:0] RCP_ERA  =
    RCP_W'(((64'd1 << SH_ERA) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));
  localparam logic [RCP_W-1:0] RCP_1460 = RCP_W'(((64'd1 << SH_1460) + 64'd1459) / 64'd1460);
  localparam logic [RCP_W-1:0] RCP_365  = RCP_W'(((64'd1 << SH_365) + 64'd364) / 64'd365);

  // Day numbers of 0000-01-01 and of MAX_YEAR-12-31.
  localparam int MIN_YOE = 399;
  localparam int SER_MIN = MIN_YOE * 365 + MIN_YOE / 4 - MIN_YOE / 100 + 306;
  localparam int MAX_YS  = MAX_YEAR + ERA_YEARS;
  localparam int MAX_ERA = MAX_YS / ERA_YEARS;
  localparam int MAX_YOE = MAX_YS % ERA_YEARS;
  localparam int SER_MAX = MAX_ERA * ERA_DAYS + MAX_YOE * 365 + MAX_YOE / 4
                         - MAX_YOE / 100 + 305;
  localparam int DIFF_HI = (1 << (DIFF_W - 1)) - 1;
  localparam int DIFF_LO = -(1 << (DIFF_W - 1));

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_DIV_YA,
    OP_SER_A,
    OP_DIV_YB,
    OP_SER_B,
    OP_DIV_Z,
    OP_DIV_DOE,
    OP_DIV_X,
    OP_FINISH,
    OP_LOAD
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT_A,
    ST_DIV_B,
    ST_WAIT_B,
    ST_RANGE,
    ST_WAIT_Z,
    ST_WAIT_1460,
    ST_WAIT_365,
    ST_LOAD
  } state_t;

  typedef enum logic [1:0] {
    DIV_400,
    DIV_ERA,
    DIV_1460,
    DIV_365
  } div_sel_t;

  typedef struct packed {
    logic div_busy;
    logic invalid;
    logic sm_oor;
    logic out_free;
  } dp_status_t;

  // Leap test; y / 100 is taken as (y * 5243) >> 19, exact for 14-bit years.
  function automatic logic is_leap(logic [YEAR_W-1:0] y);
    logic [26:0] prod;
    logic [7:0]  q;
    logic [YEAR_W-1:0] r;
    prod = 27'(y) * 27'd5243;
    q    = prod[26:19];
    r    = y - YEAR_W'(q) * YEAR_W'(100);
    return (y[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(logic [YEAR_W-1:0] y,
                                                 logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic date_ok(logic [YEAR_W-1:0] y, logic [MON_W-1:0] m,
                                   logic [DAY_W-1:0] d);
    return (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= month_len(y, m));
  endfunction

  // Days from March 1 to the first of the shifted month index (0 = March).
  function automatic logic [8:0] cum_of_mp(logic [3:0] mp);
    logic [8:0] v;
    unique case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Calendar month to the March-based month index.
  function automatic logic [3:0] mp_of_month(logic [MON_W-1:0] m);
    return (m <= 4'd2) ? 4'(m + 4'd9) : 4'(m - 4'd3);
  endfunction

  // Century count of a year inside a 400-year era.
  function automatic logic [1:0] cent_of(logic [8:0] yoe);
    logic [1:0] c;
    priority if (yoe >= 9'd300) c = 2'd3;
    else if (yoe >= 9'd200)     c = 2'd2;
    else if (yoe >= 9'd100)     c = 2'd1;
    else                        c = 2'd0;
    return c;
  endfunction

endpackage
`default_nettype wire

### sv/gregorian_date_calculator.sv
// Top level of the proleptic Gregorian date calculator.
//
//   channel  direction  handshake           contents
//   in_      input      in_valid/in_stall   two dates and a signed day offset
//   out_     output     out_valid/out_stall moved date, difference, flags
//
// A transaction runs alone from its acceptance until its result is loaded: the
// shared divider runs five times in it, between the sequencing states.
// A transaction with an invalid date skips all five divides, and one whose moved
// date falls out of range skips the last three.
// Reset is synchronous and active low; it empties the result register.
// A stalled result stays in its register while the next transaction runs.
`default_nettype none
module gregorian_date_calculator (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [gdc_pkg::YEAR_W-1:0]             in_year_a,
  input  wire logic [gdc_pkg::MON_W-1:0]              in_month_a,
  input  wire logic [gdc_pkg::DAY_W-1:0]              in_day_a,
  input  wire logic [gdc_pkg::YEAR_W-1:0]             in_year_b,
  input  wire logic [gdc_pkg::MON_W-1:0]              in_month_b,
  input  wire logic [gdc_pkg::DAY_W-1:0]              in_day_b,
  input  wire logic signed [gdc_pkg::OFFSET_BITS-1:0] in_offset_days,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [gdc_pkg::YEAR_W-1:0]                  out_moved_year,
  output logic [gdc_pkg::MON_W-1:0]                   out_moved_month,
  output logic [gdc_pkg::DAY_W-1:0]                   out_moved_day,
  output logic signed [gdc_pkg::DIFF_W-1:0]           out_day_difference,
  output logic                                        out_a_after_b,
  output logic                                        out_a_equals_b,
  output logic                                        out_input_invalid,
  output logic                                        out_out_of_range
);
  import gdc_pkg::*;

  op_t        op;
  dp_status_t status;

  gdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  gdc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .op                 (op),
    .status             (status),
    .in_year_a          (in_year_a),
    .in_month_a         (in_month_a),
    .in_day_a           (in_day_a),
    .in_year_b          (in_year_b),
    .in_month_b         (in_month_b),
    .in_day_b           (in_day_b),
    .in_offset_days     (in_offset_days),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_moved_year     (out_moved_year),
    .out_moved_month    (out_moved_month),
    .out_moved_day      (out_moved_day),
    .out_day_difference (out_day_difference),
    .out_a_after_b      (out_a_after_b),
    .out_a_equals_b     (out_a_equals_b),
    .out_input_invalid  (out_input_invalid),
    .out_out_of_range   (out_out_of_range)
  );

endmodule
`default_nettype wire

### sv/gdc_div.sv
// Divider by the calendar constants, by reciprocal multiplication: quotient, then remainder.
`default_nettype none
module gdc_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [gdc_pkg::DIVD_W-1:0] dividend,
  input  wire gdc_pkg::div_sel_t          sel,
  output logic                            busy,
  output logic [gdc_pkg::DIVD_W-1:0]      quot,
  output logic [gdc_pkg::DIVS_W-1:0]      rem
);
  import gdc_pkg::*;

  logic [DIVD_W-1:0]       num_r;
  div_sel_t                sel_r;
  logic                    mul_r, mul_nxt;
  logic                    sub_r, sub_nxt;
  logic [DIVD_W-1:0]       q_r, q_nxt;
  logic [DIVS_W-1:0]       rem_r, rem_nxt;
  logic [RCP_W-1:0]        rcp;
  logic [DIVS_W-1:0]       den;
  logic [DIVD_W+RCP_W-1:0] prod;
  logic [DIVD_W-1:0]       q_est;
  logic [DIVD_W-1:0]       back;

  // Step mul_r: quotient from the reciprocal product. Step sub_r, after it: remainder.
  always_comb begin
    unique case (sel_r)
      DIV_400: begin
        rcp = RCP_400;
        den = DIVS_W'(ERA_YEARS);
      end
      DIV_ERA: begin
        rcp = RCP_ERA;
        den = DIVS_W'(ERA_DAYS);
      end
      DIV_1460: begin
        rcp = RCP_1460;
        den = DIVS_W'(1460);
      end
      DIV_365: begin
        rcp = RCP_365;
        den = DIVS_W'(365);
      end
    endcase
    prod = (DIVD_W + RCP_W)'(num_r) * (DIVD_W + RCP_W)'(rcp);
    unique case (sel_r)
      DIV_400:  q_est = DIVD_W'(prod >> SH_400);
      DIV_ERA:  q_est = DIVD_W'(prod >> SH_ERA);
      DIV_1460: q_est = DIVD_W'(prod >> SH_1460);
      DIV_365:  q_est = DIVD_W'(prod >> SH_365);
    endcase
    back    = q_r * DIVD_W'(den);
    mul_nxt = start;
    sub_nxt = mul_r;
    q_nxt   = mul_r ? q_est : q_r;
    rem_nxt = sub_r ? DIVS_W'(num_r - back) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r <= 1'b0;
      sub_r <= 1'b0;
      sel_r <= DIV_400;
    end else begin
      mul_r <= mul_nxt;
      sub_r <= sub_nxt;
      if (start) begin
        sel_r <= sel;
      end
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      num_r <= dividend;
    end
  end

  assign busy = mul_r || sub_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

### sv/gdc_dp.sv
// Datapath: operand registers, day-number arithmetic, divider and result register.
`default_nettype none
module gdc_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire gdc_pkg::op_t                           op,
  output gdc_pkg::dp_status_t                         status,
  input  wire logic [gdc_pkg::YEAR_W-1:0]             in_year_a,
  input  wire logic [gdc_pkg::MON_W-1:0]              in_month_a,
  input  wire logic [gdc_pkg::DAY_W-1:0]              in_day_a,
  input  wire logic [gdc_pkg::YEAR_W-1:0]             in_year_b,
  input  wire logic [gdc_pkg::MON_W-1:0]              in_month_b,
  input  wire logic [gdc_pkg::DAY_W-1:0]              in_day_b,
  input  wire logic signed [gdc_pkg::OFFSET_BITS-1:0] in_offset_days,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [gdc_pkg::YEAR_W-1:0]                  out_moved_year,
  output logic [gdc_pkg::MON_W-1:0]                   out_moved_month,
  output logic [gdc_pkg::DAY_W-1:0]                   out_moved_day,
  output logic signed [gdc_pkg::DIFF_W-1:0]           out_day_difference,
  output logic                                        out_a_after_b,
  output logic                                        out_a_equals_b,
  output logic                                        out_input_invalid,
  output logic                                        out_out_of_range
);
  import gdc_pkg::*;

  function automatic logic [SER_W-1:0] ser_calc(logic [5:0] era, logic [8:0] yoe,
                                                logic [MON_W-1:0] m, logic [DAY_W-1:0] d);
    logic [17:0] doe;
    logic [23:0] e;
    doe = 18'(yoe) * 18'd365 + 18'(yoe >> 2) - 18'(cent_of(yoe))
        + 18'(cum_of_mp(mp_of_month(m))) + 18'(d) - 18'd1;
    e = 24'(era) * 24'(ERA_DAYS);
    return SER_W'(e + 24'(doe));
  endfunction

  logic [YEAR_W-1:0]             ya_r, yb_r;
  logic [MON_W-1:0]              ma_r, mb_r;
  logic [DAY_W-1:0]              da_r, db_r;
  logic signed [OFFSET_BITS-1:0] off_r;
  logic [SER_W-1:0]              sa_r, sb;
  logic signed [SM_W-1:0]        sm_r, sm;
  logic signed [SER_W:0]         dv;
  logic signed [DIFF_W-1:0]      diff_r;
  logic                          after_r, eq_r, sm_oor_r, diff_oor_r;
  logic [4:0]                    era_r;
  logic [17:0]                   doe_r;
  logic [YEAR_W-1:0]             mv_y_r;
  logic [MON_W-1:0]              mv_m_r;
  logic [DAY_W-1:0]              mv_d_r;
  logic                          inv;

  logic                          out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]             o_y_r;
  logic [MON_W-1:0]              o_m_r;
  logic [DAY_W-1:0]              o_d_r;
  logic signed [DIFF_W-1:0]      o_diff_r;
  logic                          o_after_r, o_eq_r, o_inv_r, o_oor_r;

  logic                          div_start, div_busy;
  logic [DIVD_W-1:0]             div_num, div_q;
  logic [DIVS_W-1:0]             div_r;
  div_sel_t                      div_sel;

  logic [17:0]                   x_val;
  logic [2:0]                    c36524;
  logic [8:0]                    yoe_f;
  logic [17:0]                   doy_w;
  logic [8:0]                    doy;
  logic [3:0]                    mp;
  logic [MON_W-1:0]              mm;
  logic [DAY_W-1:0]              dd;
  logic [14:0]                   yy;

  gdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .sel      (div_sel),
    .busy     (div_busy),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign inv = !date_ok(ya_r, ma_r, da_r) || !date_ok(yb_r, mb_r, db_r);

  // Second serial number and everything that follows from the pair.
  assign sb = ser_calc(div_q[5:0], div_r[8:0], mb_r, db_r);
  assign sm = $signed(SM_W'(sa_r)) + SM_W'(off_r);
  assign dv = $signed({1'b0, sa_r}) - $signed({1'b0, sb});

  // Year-of-era numerator for the 365-day divide.
  always_comb begin
    priority if (doe_r >= 18'd146096) c36524 = 3'd4;
    else if (doe_r >= 18'd109572)     c36524 = 3'd3;
    else if (doe_r >= 18'd73048)      c36524 = 3'd2;
    else if (doe_r >= 18'd36524)      c36524 = 3'd1;
    else                              c36524 = 3'd0;
    x_val = doe_r - 18'(div_q[6:0]) + 18'(c36524) - ((doe_r == 18'd146096) ? 18'd1 : 18'd0);
  end

  // Day of year to month and day.
  always_comb begin
    yoe_f = div_q[8:0];
    doy_w = doe_r - (18'(yoe_f) * 18'd365 + 18'(yoe_f >> 2) - 18'(cent_of(yoe_f)));
    doy   = doy_w[8:0];
    mp    = '0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= cum_of_mp(4'(k))) begin
        mp = 4'(k);
      end
    end
    dd = DAY_W'(doy - cum_of_mp(mp) + 9'd1);
    mm = (mp < 4'd10) ? MON_W'(mp + 4'd3) : MON_W'(mp - 4'd9);
    yy = 15'(yoe_f) + 15'(era_r) * 15'd400 + ((mm <= 4'd2) ? 15'd1 : 15'd0) - 15'd400;
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_sel   = DIV_400;
    unique case (op)
      OP_DIV_YA: begin
        div_start = 1'b1;
        div_num   = DIVD_W'(15'(ya_r) + 15'd400 - ((ma_r <= 4'd2) ? 15'd1 : 15'd0));
      end
      OP_DIV_YB: begin
        div_start = 1'b1;
        div_num   = DIVD_W'(15'(yb_r) + 15'd400 - ((mb_r <= 4'd2) ? 15'd1 : 15'd0));
      end
      OP_DIV_Z: begin
        div_start = 1'b1;
        div_num   = DIVD_W'(sm_r);
        div_sel   = DIV_ERA;
      end
      OP_DIV_DOE: begin
        div_start = 1'b1;
        div_num   = DIVD_W'(div_r);
        div_sel   = DIV_1460;
      end
      OP_DIV_X: begin
        div_start = 1'b1;
        div_num   = DIVD_W'(x_val);
        div_sel   = DIV_365;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_CAPTURE: begin
        ya_r  <= in_year_a;
        ma_r  <= in_month_a;
        da_r  <= in_day_a;
        yb_r  <= in_year_b;
        mb_r  <= in_month_b;
        db_r  <= in_day_b;
        off_r <= in_offset_days;
      end
      OP_SER_A: begin
        sa_r <= ser_calc(div_q[5:0], div_r[8:0], ma_r, da_r);
      end
      OP_SER_B: begin
        sm_r       <= sm;
        sm_oor_r   <= (sm < $signed(SM_W'(SER_MIN))) || (sm > $signed(SM_W'(SER_MAX)));
        diff_r     <= DIFF_W'(dv);
        diff_oor_r <= (dv > $signed((SER_W + 1)'(DIFF_HI))) ||
                      (dv < $signed((SER_W + 1)'(DIFF_LO)));
        after_r    <= sa_r > sb;
        eq_r       <= sa_r == sb;
      end
      OP_DIV_DOE: begin
        era_r <= div_q[4:0];
        doe_r <= div_r;
      end
      OP_FINISH: begin
        mv_y_r <= YEAR_W'(yy);
        mv_m_r <= mm;
        mv_d_r <= dd;
      end
      OP_LOAD: begin
        o_inv_r   <= inv;
        o_y_r     <= (inv || sm_oor_r) ? '0 : mv_y_r;
        o_m_r     <= (inv || sm_oor_r) ? '0 : mv_m_r;
        o_d_r     <= (inv || sm_oor_r) ? '0 : mv_d_r;
        o_diff_r  <= (inv || diff_oor_r) ? '0 : diff_r;
        o_after_r <= !inv && after_r;
        o_eq_r    <= !inv && eq_r;
        o_oor_r   <= !inv && (sm_oor_r || diff_oor_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (op == OP_LOAD) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.div_busy = div_busy;
  assign status.invalid  = inv;
  assign status.sm_oor   = sm_oor_r;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_moved_year     = o_y_r;
  assign out_moved_month    = o_m_r;
  assign out_moved_day      = o_d_r;
  assign out_day_difference = o_diff_r;
  assign out_a_after_b      = o_after_r;
  assign out_a_equals_b     = o_eq_r;
  assign out_input_invalid  = o_inv_r;
  assign out_out_of_range   = o_oor_r;

endmodule
`default_nettype wire

### sv/gdc_ctrl.sv
// Controller: sequences one transaction through the datapath operations.
`default_nettype none
module gdc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire gdc_pkg::dp_status_t status,
  output gdc_pkg::op_t             op
);
  import gdc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = OP_CAPTURE;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.invalid) begin
          state_nxt = ST_LOAD;
        end else begin
          op        = OP_DIV_YA;
          state_nxt = ST_WAIT_A;
        end
      end
      ST_WAIT_A: begin
        if (!status.div_busy) begin
          op        = OP_SER_A;
          state_nxt = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        op        = OP_DIV_YB;
        state_nxt = ST_WAIT_B;
      end
      ST_WAIT_B: begin
        if (!status.div_busy) begin
          op        = OP_SER_B;
          state_nxt = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (status.sm_oor) begin
          state_nxt = ST_LOAD;
        end else begin
          op        = OP_DIV_Z;
          state_nxt = ST_WAIT_Z;
        end
      end
      ST_WAIT_Z: begin
        if (!status.div_busy) begin
          op        = OP_DIV_DOE;
          state_nxt = ST_WAIT_1460;
        end
      end
      ST_WAIT_1460: begin
        if (!status.div_busy) begin
          op        = OP_DIV_X;
          state_nxt = ST_WAIT_365;
        end
      end
      ST_WAIT_365: begin
        if (!status.div_busy) begin
          op        = OP_FINISH;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status.out_free) begin
          op        = OP_LOAD;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule
`default_nettype wire

### sv/gdc_chk.sv
// Port-level checker of the date calculator and its bind statement.
`default_nettype none
`include "gregorian_date_calculator_macros.svh"
module gdc_chk (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [gdc_pkg::YEAR_W-1:0]   out_moved_year,
  input wire logic [gdc_pkg::MON_W-1:0]    out_moved_month,
  input wire logic [gdc_pkg::DAY_W-1:0]    out_moved_day,
  input wire logic [gdc_pkg::DIFF_W-1:0]   out_day_difference,
  input wire logic                         out_a_after_b,
  input wire logic                         out_a_equals_b,
  input wire logic                         out_input_invalid,
  input wire logic                         out_out_of_range
);
  import gdc_pkg::*;

  // A stalled result stays valid and keeps its day difference and moved year.
  `GDC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_day_difference) && $stable(out_moved_year))

  // An invalid date clears every other result field.
  `GDC_ASSERT_NOW(a_inv_zero, out_valid && out_input_invalid, out_moved_year == '0 && out_moved_month == '0 && out_moved_day == '0 && out_day_difference == '0 && !out_a_after_b && !out_a_equals_b && !out_out_of_range)

  // Equal dates give a zero difference and are not ordered.
  `GDC_ASSERT_NOW(a_eq_zero, out_valid && out_a_equals_b, out_day_difference == '0 && !out_a_after_b)

  // A moved date inside the range has a month from 1 to 12 and a nonzero day.
  `GDC_ASSERT_NOW(a_moved_ok, out_valid && !out_input_invalid && !out_out_of_range, out_moved_month >= 4'd1 && out_moved_month <= 4'd12 && out_moved_day >= 5'd1)

endmodule

bind gregorian_date_calculator gdc_chk u_chk (.*);
`default_nettype wire

### sim/tb_gregorian_date_calculator.sv
// Self-checking testbench of the proleptic Gregorian date calculator.
`timescale 1ns / 100ps
`default_nettype none
module tb_gregorian_date_calculator;
  import gdc_pkg::*;

  typedef struct {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic signed [DIFF_W-1:0] diff;
    logic after, same, invalid, oor;
  } date_result_t;

  typedef struct {
    logic [YEAR_W-1:0] ya, yb;
    logic [MON_W-1:0]  ma, mb;
    logic [DAY_W-1:0]  da, db;
    logic signed [OFFSET_BITS-1:0] off;
  } date_request_t;

  class date_scoreboard;
    date_result_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function bit leap_year(longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function longint month_days(longint y, longint m);
      longint lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m == 2 && leap_year(y)) return 29;
      return lens[m];
    endfunction

    static function bit legal(longint y, longint m, longint d);
      if (m < 1 || m > 12) return 0;
      return d >= 1 && d <= month_days(y, m);
    endfunction

    // Day number, counted from an era before year 0 so nothing goes negative.
    static function longint day_number(longint y, longint m, longint d);
      longint ys, era, yoe, mp, doy;
      ys = y + 400 - (m <= 2 ? 1 : 0);
      era = ys / 400;
      yoe = ys - era * 400;
      mp = (m + 9) % 12;
      doy = (153 * mp + 2) / 5 + d - 1;
      return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
    endfunction

    function void note_request(date_request_t r);
      date_result_t e;
      longint sa, sb, sm, era, doe, yoe, yy, doy, mp;
      e = '{default: 0};
      if (!legal(r.ya, r.ma, r.da) || !legal(r.yb, r.mb, r.db)) begin
        e.invalid = 1;
      end else begin
        sa = day_number(r.ya, r.ma, r.da);
        sb = day_number(r.yb, r.mb, r.db);
        sm = sa + longint'(r.off);
        if (sm < day_number(0, 1, 1) || sm > day_number(MAX_YEAR, 12, 31)) begin
          e.oor = 1;
        end else begin
          era = sm / 146097;
          doe = sm - era * 146097;
          yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
          yy = yoe + era * 400;
          doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
          mp = (5 * doy + 2) / 153;
          e.day = DAY_W'(doy - (153 * mp + 2) / 5 + 1);
          e.month = MON_W'(mp < 10 ? mp + 3 : mp - 9);
          if (mp >= 10) yy++;
          e.year = YEAR_W'(yy - 400);
        end
        if (sa - sb >= (64'sd1 <<< (DIFF_W - 1)) || sa - sb < -(64'sd1 <<< (DIFF_W - 1)))
          e.oor = 1;
        else
          e.diff = DIFF_W'(sa - sb);
        e.after = sa > sb;
        e.same = sa == sb;
      end
      pending.push_back(e);
    endfunction

    function void check_result(date_result_t got);
      date_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result year %0d", $time, got.year);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.year !== e.year || got.month !== e.month || got.day !== e.day ||
          got.diff !== e.diff || got.after !== e.after || got.same !== e.same ||
          got.invalid !== e.invalid || got.oor !== e.oor) begin
        $display("%0t: mismatch expected %0d-%0d-%0d diff %0d flags %b%b%b%b",
                 $time, e.year, e.month, e.day, e.diff, e.after, e.same, e.invalid, e.oor);
        $display("%0t:          actual   %0d-%0d-%0d diff %0d flags %b%b%b%b",
                 $time, got.year, got.month, got.day, got.diff, got.after, got.same,
                 got.invalid, got.oor);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [YEAR_W-1:0] in_year_a, in_year_b, out_moved_year;
  logic [MON_W-1:0]  in_month_a, in_month_b, out_moved_month;
  logic [DAY_W-1:0]  in_day_a, in_day_b, out_moved_day;
  logic signed [OFFSET_BITS-1:0] in_offset_days;
  logic signed [DIFF_W-1:0] out_day_difference;
  logic out_a_after_b, out_a_equals_b, out_input_invalid, out_out_of_range;

  date_scoreboard board = new();
  bit calm;            // no idling on either side
  bit hold_receiver;   // long receiver hold-off
  int quiet_cycles;

  gregorian_date_calculator uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Bookkeeping at the rising edge: inputs and outputs are stable there.
  always @(posedge clk) begin
    date_result_t r;
    bit moved;
    moved = 0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note_request('{ya: in_year_a, yb: in_year_b, ma: in_month_a,
                             mb: in_month_b, da: in_day_a, db: in_day_b,
                             off: in_offset_days});
        moved = 1;
      end
      if (out_valid && !out_stall) begin
        r = '{year: out_moved_year, month: out_moved_month, day: out_moved_day,
              diff: out_day_difference, after: out_a_after_b, same: out_a_equals_b,
              invalid: out_input_invalid, oor: out_out_of_range};
        board.check_result(r);
        moved = 1;
      end
      if (quiet_cycles > 20000) begin
        $display("FAIL");
        $finish;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end else begin
      quiet_cycles <= 0;
    end
  end

  // Receiver: random stall, long stretches of none, one long hold-off.
  always @(negedge clk) begin
    if (!rst_n)
      out_stall <= 0;
    else if (hold_receiver)
      out_stall <= 1;
    else
      out_stall <= !calm && ($urandom_range(99) < 37);
  end

  // Valid stays high after acceptance; the next call may lower it, drain() lowers it.
  task automatic send(date_request_t r);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_year_a <= r.ya;
    in_month_a <= r.ma;
    in_day_a <= r.da;
    in_year_b <= r.yb;
    in_month_b <= r.mb;
    in_day_b <= r.db;
    in_offset_days <= r.off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic date_request_t legal_request(bit full_offset);
    date_request_t r;
    r.ya = YEAR_W'($urandom_range(MAX_YEAR));
    r.ma = MON_W'($urandom_range(12, 1));
    r.da = DAY_W'($urandom_range(date_scoreboard::month_days(r.ya, r.ma), 1));
    if ($urandom_range(3) == 0) begin
      r.yb = r.ya;
      r.mb = r.ma;
      r.db = ($urandom_range(1)) ? r.da : DAY_W'($urandom_range(28, 1));
    end else begin
      r.yb = YEAR_W'($urandom_range(MAX_YEAR));
      r.mb = MON_W'($urandom_range(12, 1));
      r.db = DAY_W'($urandom_range(date_scoreboard::month_days(r.yb, r.mb), 1));
    end
    if (full_offset) r.off = OFFSET_BITS'($urandom);
    else r.off = OFFSET_BITS'(int'($urandom_range(2000)) - 1000);
    return r;
  endfunction

  function automatic date_request_t noise_request();
    date_request_t r;
    r.ya = YEAR_W'($urandom);
    r.yb = YEAR_W'($urandom);
    r.ma = MON_W'($urandom);
    r.mb = MON_W'($urandom);
    r.da = DAY_W'($urandom);
    r.db = DAY_W'($urandom);
    r.off = OFFSET_BITS'($urandom);
    return r;
  endfunction

  initial begin
    date_request_t r;
    int n;
    rst_n = 0;
    in_valid = 0;
    calm = 1;
    hold_receiver = 0;
    {in_year_a, in_month_a, in_day_a, in_year_b, in_month_b, in_day_b} = '0;
    in_offset_days = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: extremes, leap rules, invalid dates, range edges.
    send('{ya: 0, ma: 1, da: 1, yb: 0, mb: 1, db: 1, off: 0});
    send('{ya: 0, ma: 1, da: 1, yb: 0, mb: 1, db: 1, off: -1});
    send('{ya: 9999, ma: 12, da: 31, yb: 0, mb: 1, db: 1, off: 1});
    send('{ya: 9999, ma: 12, da: 31, yb: 0, mb: 1, db: 1, off: 0});
    send('{ya: 0, ma: 1, da: 1, yb: 9999, mb: 12, db: 31, off: 21'sh0FFFFF});
    send('{ya: 9999, ma: 12, da: 31, yb: 9999, mb: 12, db: 30, off: 21'sh100000});
    send('{ya: 2000, ma: 2, da: 29, yb: 1900, mb: 2, db: 28, off: 365});
    send('{ya: 1900, ma: 2, da: 29, yb: 2000, mb: 1, db: 1, off: 0});
    send('{ya: 2004, ma: 2, da: 29, yb: 2004, mb: 3, db: 1, off: 1});
    send('{ya: 2100, ma: 3, da: 1, yb: 2100, mb: 2, db: 28, off: -1});
    send('{ya: 2023, ma: 0, da: 1, yb: 2023, mb: 1, db: 1, off: 5});
    send('{ya: 2023, ma: 13, da: 1, yb: 2023, mb: 1, db: 1, off: 5});
    send('{ya: 2023, ma: 15, da: 31, yb: 2023, mb: 1, db: 1, off: 5});
    send('{ya: 2023, ma: 4, da: 31, yb: 2023, mb: 1, db: 1, off: 5});
    send('{ya: 2023, ma: 1, da: 0, yb: 2023, mb: 1, db: 1, off: 5});
    send('{ya: 2023, ma: 1, da: 1, yb: 2023, mb: 6, db: 31, off: 5});
    send('{ya: 16383, ma: 12, da: 31, yb: 0, mb: 1, db: 1, off: -5});
    send('{ya: 10000, ma: 1, da: 1, yb: 9999, mb: 12, db: 31, off: -1});
    send('{ya: 12000, ma: 2, da: 29, yb: 0, mb: 1, db: 1, off: 21'sh100000});
    send('{ya: 16383, ma: 6, da: 15, yb: 16383, mb: 6, db: 15, off: 21'sh0FFFFF});
    send('{ya: 1999, ma: 12, da: 31, yb: 2000, mb: 1, db: 1, off: -730000});
    drain();

    // Fill the block while the receiver holds off.
    calm = 1;
    hold_receiver = 1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_receiver = 0;
      end
      for (int i = 0; i < 6; i++) send(legal_request(0));
    join
    drain();

    for (n = 0; n < 1520; n++) begin
      calm = (n >= 300 && n < 500);
      if (n == 900) drain();
      case ($urandom_range(9))
        0, 1: r = noise_request();
        2, 3: r = legal_request(1);
        default: r = legal_request(0);
      endcase
      send(r);
    end
    drain();
    repeat (200) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
